// ===== hdl/absel_pkg.sv =====
// ----------------------------------------------------------------------------
// absel_pkg
// Shared types and codes for the A/B selector: mode codes, register indexes
// and fixed field widths.
// ----------------------------------------------------------------------------
package absel_pkg;

   localparam int CHANNEL_BITS   = 4;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam int THRESH_BITS    = 16;
   localparam int BIAS_BITS      = 15;
   localparam int DELTA_BITS     = 15;

   typedef logic [1:0]                mode_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam mode_type MODE_THRESH = 2'd0;
   localparam mode_type MODE_BIAS   = 2'd1;
   localparam mode_type MODE_RISE   = 2'd2;

   localparam csr_index_type CSR_MODE       = 3'd0;
   localparam csr_index_type CSR_THRESHOLD  = 3'd1;
   localparam csr_index_type CSR_BIAS       = 3'd2;
   localparam csr_index_type CSR_RISE_DELTA = 3'd3;
   localparam csr_index_type CSR_GATE_ON_B  = 3'd4;

endpackage

// ===== hdl/ab_selector_three_mode_core.sv =====
// ----------------------------------------------------------------------------
// ab_selector_three_mode_core
// Per-channel A/B sample switch with threshold, A-versus-B-plus-bias and
// rise/fall selection modes, and a gate output of selectable polarity.
// ----------------------------------------------------------------------------
// Takes one sample pair per clock unless the result side stalls and returns one
// result per pair through the compute and output registers. The per-channel
// history (last A and the choice flag) sits in a CHANNELS-deep memory with a
// registered read: read at the input transfer, written back as the pair leaves
// the compute stage, and picked up directly by a following pair on the same
// channel. Per-channel valid bits make it read as zero / choose-A after reset,
// so no clearing pass is needed. Write the registers only while idle.
module ab_selector_three_mode_core
   import absel_pkg::*;
#(
   parameter int CHANNELS    = 16,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // channel, a_sample, b_sample, zero fill
   input  logic [((CHANNEL_BITS+2*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // out_channel, chosen_sample, zero fill
   output logic [((CHANNEL_BITS+SAMPLE_BITS+7)/8)*8-1:0]   rsp_tdata,
   // picked_a, gate
   output logic [1:0]                rsp_tuser,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int RSP_W     = ((CHANNEL_BITS+SAMPLE_BITS+7)/8)*8;
   localparam int ADDR_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CMP_W     = ((SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS) + 2;
   localparam int WORD_W    = SAMPLE_BITS + 1;

   // configuration
   mode_type                      mode_ff;
   logic signed [THRESH_BITS-1:0] thresh_ff;
   logic signed [BIAS_BITS-1:0]   bias_ff;
   logic [DELTA_BITS-1:0]         delta_ff;
   logic                          gate_on_b_ff;

   // input side
   logic                          accept;
   logic [CHANNEL_BITS-1:0]       req_ch;
   logic signed [SAMPLE_BITS-1:0] req_a;
   logic signed [SAMPLE_BITS-1:0] req_b;
   logic [ADDR_BITS-1:0]          rd_addr;
   logic                          req_in_range;

   // compute stage
   logic                          s1_vld_ff;
   logic [CHANNEL_BITS-1:0]       s1_ch_ff;
   logic signed [SAMPLE_BITS-1:0] s1_a_ff;
   logic signed [SAMPLE_BITS-1:0] s1_b_ff;
   logic [ADDR_BITS-1:0]          s1_addr_ff;
   logic                          s1_in_range_ff;
   logic                          advance;

   // history memory
   logic [WORD_W-1:0]             mem [CHANNELS];
   logic [CHANNELS-1:0]           ent_vld_ff;
   logic [WORD_W-1:0]             rd_word_ff;
   logic                          rd_vld_ff;
   logic                          mem_we;
   logic [WORD_W-1:0]             word_in;

   // arithmetic
   logic signed [SAMPLE_BITS-1:0] prev_a;
   logic                          prev_flag;
   logic signed [CMP_W-1:0]       a_w;
   logic signed [CMP_W-1:0]       b_w;
   logic signed [CMP_W-1:0]       prev_w;
   logic signed [CMP_W-1:0]       thresh_w;
   logic signed [CMP_W-1:0]       bias_w;
   logic signed [CMP_W-1:0]       delta_w;
   logic signed [CMP_W-1:0]       diff_w;
   logic                          flag_in;
   logic                          pick_a;

   // output register
   logic                          rsp_vld_ff;
   logic [RSP_W-1:0]              rsp_data_ff;
   logic [1:0]                    rsp_user_ff;

   assign req_ch       = req_tdata[CHANNEL_BITS-1:0];
   assign req_a        = req_tdata[CHANNEL_BITS +: SAMPLE_BITS];
   assign req_b        = req_tdata[CHANNEL_BITS+SAMPLE_BITS +: SAMPLE_BITS];
   assign rd_addr      = ADDR_BITS'(req_ch);
   assign req_in_range = 32'(req_ch) < CHANNELS;

   assign advance    = !rsp_vld_ff || rsp_tready;
   assign req_tready = !s1_vld_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_THRESH;
         thresh_ff    <= '0;
         bias_ff      <= '0;
         delta_ff     <= '0;
         gate_on_b_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE:       mode_ff      <= csr_wdata[1:0];
            CSR_THRESHOLD:  thresh_ff    <= csr_wdata[THRESH_BITS-1:0];
            CSR_BIAS:       bias_ff      <= csr_wdata[BIAS_BITS-1:0];
            CSR_RISE_DELTA: delta_ff     <= csr_wdata[DELTA_BITS-1:0];
            CSR_GATE_ON_B:  gate_on_b_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // compute stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (accept) begin
         s1_vld_ff <= 1'b1;
      end else if (advance) begin
         s1_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ch_ff       <= req_ch;
         s1_a_ff        <= req_a;
         s1_b_ff        <= req_b;
         s1_addr_ff     <= rd_addr;
         s1_in_range_ff <= req_in_range;
      end
   end

   // read at transfer, bypass a write-back to the same channel
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[s1_addr_ff] <= word_in;
      end
      if (accept) begin
         if (mem_we && s1_addr_ff == rd_addr) begin
            rd_word_ff <= word_in;
         end else begin
            rd_word_ff <= mem[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (mem_we) begin
            ent_vld_ff[s1_addr_ff] <= 1'b1;
         end
         if (accept) begin
            rd_vld_ff <= (mem_we && s1_addr_ff == rd_addr) || ent_vld_ff[rd_addr];
         end
      end
   end

   assign prev_a    = rd_vld_ff ? rd_word_ff[SAMPLE_BITS-1:0] : '0;
   assign prev_flag = rd_vld_ff ? rd_word_ff[SAMPLE_BITS] : 1'b1;

   assign a_w      = CMP_W'(s1_a_ff);
   assign b_w      = CMP_W'(s1_b_ff);
   assign prev_w   = CMP_W'(prev_a);
   assign thresh_w = CMP_W'(thresh_ff);
   assign bias_w   = CMP_W'(bias_ff);
   assign delta_w  = signed'(CMP_W'(delta_ff));
   assign diff_w   = a_w - prev_w;

   always_comb begin
      if (diff_w > delta_w) begin
         flag_in = 1'b1;
      end else if (diff_w < -delta_w) begin
         flag_in = 1'b0;
      end else begin
         flag_in = prev_flag;
      end
   end

   always_comb begin
      case (mode_ff)
         MODE_THRESH: pick_a = a_w >= thresh_w;
         MODE_BIAS:   pick_a = a_w >= (b_w + bias_w);
         MODE_RISE:   pick_a = s1_in_range_ff ? flag_in : 1'b1;
         default:     pick_a = 1'b1;
      endcase
   end

   assign mem_we  = s1_vld_ff && advance && mode_ff == MODE_RISE && s1_in_range_ff;
   assign word_in = {flag_in, s1_a_ff};

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_vld_ff) begin
         rsp_data_ff <= RSP_W'({pick_a ? s1_a_ff : s1_b_ff, s1_ch_ff});
         rsp_user_ff <= {pick_a ^ gate_on_b_ff, pick_a};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_accept_loads : assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_vld_ff)
      else $error("transfer did not load compute stage");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && !advance |=> s1_vld_ff && $stable(s1_ch_ff) && $stable(rd_word_ff))
      else $error("stalled item lost or corrupted");

   a_we_mode : assert property (@(posedge clock) disable iff (reset)
      mem_we |-> s1_vld_ff && mode_ff == MODE_RISE)
      else $error("history written outside rise/fall mode");

   a_gate_polarity : assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && $stable(gate_on_b_ff) |-> rsp_user_ff[1] == (rsp_user_ff[0] ^ gate_on_b_ff))
      else $error("gate polarity mismatch");

endmodule
